// ===== rtl/tsrg_pkg.sv =====
// Shared types, constants and the control program of the two-seed random generator.
`timescale 1ns / 1ps
package tsrg_pkg;

  localparam logic [31:0] MODULUS        = 32'd2147483647;
  localparam logic [16:0] SQRT3_Q16      = 17'd113512;
  localparam logic [31:0] RST_MULT_ONE   = 32'd217828199;
  localparam logic [31:0] RST_MULT_TWO   = 32'd314159269;
  localparam logic [31:0] RST_SEED_OLD   = 32'd111111;
  localparam logic [31:0] RST_SEED_NEW   = 32'd1111111;
  localparam int          GAUSS_ROOT_MAX = 8;

  localparam int IN_W    = 24;
  localparam int OUT_W   = 32;
  localparam int CFG_IDX_W = 3;

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_RAW    = 3'd0;
  localparam opcode_t OP_HALF   = 3'd1;
  localparam opcode_t OP_RECT   = 3'd2;
  localparam opcode_t OP_GAUSS  = 3'd3;
  localparam opcode_t OP_RESEED = 3'd4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MULT_ONE = 3'd0;
  localparam cfg_idx_t CFG_MULT_TWO = 3'd1;
  localparam cfg_idx_t CFG_SEED_OLD = 3'd2;
  localparam cfg_idx_t CFG_SEED_NEW = 3'd3;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t PC_IDLE    = 4'd0;
  localparam pc_t PC_MUL1    = 4'd1;
  localparam pc_t PC_MUL2    = 4'd2;
  localparam pc_t PC_MOD     = 4'd3;
  localparam pc_t PC_MAG     = 4'd4;
  localparam pc_t PC_SCALE   = 4'd5;
  localparam pc_t PC_SAMP    = 4'd6;
  localparam pc_t PC_ACC     = 4'd7;
  localparam pc_t PC_DIVINIT = 4'd8;
  localparam pc_t PC_DIVSTEP = 4'd9;
  localparam pc_t PC_DIVEND  = 4'd10;
  localparam pc_t PC_EMIT    = 4'd11;
  localparam pc_t PC_RESEED  = 4'd12;
  localparam pc_t PC_ZERO    = 4'd13;

  typedef enum logic [3:0] {
    U_FETCH, U_MUL1, U_MUL2, U_MOD, U_MAG, U_SCALE, U_SAMP, U_ACC,
    U_DIVINIT, U_DIVSTEP, U_DIVEND, U_EMIT, U_RESEED, U_ZERO
  } uop_t;

  typedef enum logic [2:0] {
    C_NEXT, C_JUMP, C_DISPATCH, C_RAW, C_SINGLE, C_CNT_MORE, C_BITS_MORE, C_OUT_FREE
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic    accept;
    opcode_t opcode;
    logic    wn_zero;
    logic    is_raw;
    logic    is_gauss;
    logic    cnt_more;
    logic    bits_more;
    logic    out_free;
  } status_t;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w.uop    = U_ZERO;
    w.cond   = C_JUMP;
    w.target = PC_IDLE;
    case (pc)
      PC_IDLE:    begin w.uop = U_FETCH;   w.cond = C_DISPATCH;  w.target = PC_IDLE;    end
      PC_MUL1:    begin w.uop = U_MUL1;    w.cond = C_NEXT;      w.target = PC_IDLE;    end
      PC_MUL2:    begin w.uop = U_MUL2;    w.cond = C_NEXT;      w.target = PC_IDLE;    end
      PC_MOD:     begin w.uop = U_MOD;     w.cond = C_RAW;       w.target = PC_EMIT;    end
      PC_MAG:     begin w.uop = U_MAG;     w.cond = C_NEXT;      w.target = PC_IDLE;    end
      PC_SCALE:   begin w.uop = U_SCALE;   w.cond = C_NEXT;      w.target = PC_IDLE;    end
      PC_SAMP:    begin w.uop = U_SAMP;    w.cond = C_SINGLE;    w.target = PC_EMIT;    end
      PC_ACC:     begin w.uop = U_ACC;     w.cond = C_CNT_MORE;  w.target = PC_MUL1;    end
      PC_DIVINIT: begin w.uop = U_DIVINIT; w.cond = C_NEXT;      w.target = PC_IDLE;    end
      PC_DIVSTEP: begin w.uop = U_DIVSTEP; w.cond = C_BITS_MORE; w.target = PC_DIVSTEP; end
      PC_DIVEND:  begin w.uop = U_DIVEND;  w.cond = C_NEXT;      w.target = PC_IDLE;    end
      PC_EMIT:    begin w.uop = U_EMIT;    w.cond = C_OUT_FREE;  w.target = PC_IDLE;    end
      PC_RESEED:  begin w.uop = U_RESEED;  w.cond = C_JUMP;      w.target = PC_EMIT;    end
      PC_ZERO:    begin w.uop = U_ZERO;    w.cond = C_JUMP;      w.target = PC_EMIT;    end
      default:    begin w.uop = U_ZERO;    w.cond = C_JUMP;      w.target = PC_IDLE;    end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/tsrg_useq.sv =====
// Step counter and control program sequencer of the two-seed random generator.
`timescale 1ns / 1ps
module tsrg_useq (
  input  logic             clk,
  input  logic             rst,
  input  tsrg_pkg::status_t stat,
  output tsrg_pkg::ctrl_t   ctrl
);
  import tsrg_pkg::*;

  pc_t pc;
  pc_t pc_next;
  pc_t dispatch;

  assign ctrl = ucode(pc);

  always_comb begin
    if (stat.opcode inside {OP_RAW, OP_HALF, OP_RECT}) begin
      dispatch = PC_MUL1;
    end else if (stat.opcode == OP_GAUSS) begin
      dispatch = stat.wn_zero ? PC_ZERO : PC_MUL1;
    end else if (stat.opcode == OP_RESEED) begin
      dispatch = PC_RESEED;
    end else begin
      dispatch = PC_ZERO;
    end
  end

  always_comb begin
    pc_next = pc + pc_t'(1);
    case (ctrl.cond)
      C_NEXT:      pc_next = pc + pc_t'(1);
      C_JUMP:      pc_next = ctrl.target;
      C_DISPATCH:  pc_next = stat.accept ? dispatch : pc;
      C_RAW:       if (stat.is_raw) pc_next = ctrl.target;
      C_SINGLE:    if (!stat.is_gauss) pc_next = ctrl.target;
      C_CNT_MORE:  if (stat.cnt_more) pc_next = ctrl.target;
      C_BITS_MORE: if (stat.bits_more) pc_next = ctrl.target;
      C_OUT_FREE:  pc_next = stat.out_free ? ctrl.target : pc;
      default:     pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/tsrg_datapath.sv =====
// Seeds, configuration registers, arithmetic and output register of the generator.
`timescale 1ns / 1ps
module tsrg_datapath #(
  parameter int MAX_GAUSS_ROOT = tsrg_pkg::GAUSS_ROOT_MAX
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tsrg_pkg::ctrl_t               ctrl,
  output tsrg_pkg::status_t             stat,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tsrg_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tsrg_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import tsrg_pkg::*;

  localparam int RW = $clog2(MAX_GAUSS_ROOT + 1);
  localparam int CW = $clog2(MAX_GAUSS_ROOT * MAX_GAUSS_ROOT + 1);

  opcode_t        in_op;
  logic [15:0]    in_spread;
  logic [3:0]     in_root;
  logic [RW-1:0]  wn_sat;

  logic [31:0]    mult_one;
  logic [31:0]    mult_two;
  logic [31:0]    start_old;
  logic [31:0]    start_new;
  logic [31:0]    seed_old;
  logic [31:0]    seed_new;
  logic [31:0]    gauss_sum;

  opcode_t        op;
  logic [RW-1:0]  wn;
  logic [CW-1:0]  cnt;
  logic [32:0]    kmul;
  logic [31:0]    prod;
  logic [30:0]    a;
  logic [30:0]    mag;
  logic           neg;
  logic [63:0]    wide;
  logic [31:0]    sample;
  logic [31:0]    result;
  logic [31:0]    quo;
  logic [RW-1:0]  rem;
  logic [4:0]     bits;
  logic           dneg;
  logic           m_valid;
  logic [31:0]    m_data;

  logic           accept;
  logic           out_free;
  logic [31:0]    mod_sum;
  logic [31:0]    mod_val;
  logic [31:0]    two_a;
  logic [31:0]    samp_hi;
  logic           samp_frac;
  logic [31:0]    samp_mag;
  logic [31:0]    samp_val;
  logic [RW:0]    rem_sh;
  logic [RW:0]    rem_diff;

  assign in_op     = s_tdata[2:0];
  assign in_spread = s_tdata[18:3];
  assign in_root   = s_tdata[22:19];
  assign wn_sat    = (32'(in_root) > 32'(MAX_GAUSS_ROOT)) ? RW'(MAX_GAUSS_ROOT) : RW'(in_root);

  assign s_tready  = (ctrl.uop == U_FETCH);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_valid || m_tready;
  assign m_tvalid  = m_valid;
  assign m_tdata   = m_data;
  assign cfg_ready = 1'b1;

  assign stat.accept    = accept;
  assign stat.opcode    = in_op;
  assign stat.wn_zero   = (in_root == 4'd0);
  assign stat.is_raw    = (op == OP_RAW);
  assign stat.is_gauss  = (op == OP_GAUSS);
  assign stat.cnt_more  = (cnt > CW'(1));
  assign stat.bits_more = (bits != 5'd0);
  assign stat.out_free  = out_free;

  // Folding: 2^31 is 1 modulo 2^31-1, so the top bit is added back in.
  assign mod_sum = {1'b0, prod[30:0]} + 32'(prod[31]);
  assign mod_val = (mod_sum >= MODULUS) ? (mod_sum - MODULUS) : mod_sum;
  assign two_a   = {a, 1'b0};

  always_comb begin
    if (op == OP_HALF) begin
      samp_hi   = wide[63:32];
      samp_frac = (wide[31:0] != 32'd0);
    end else begin
      samp_hi   = 32'(wide[63:47]);
      samp_frac = (wide[46:0] != 47'd0);
    end
    samp_mag = samp_hi + 32'(neg && samp_frac);
    samp_val = neg ? (32'd0 - samp_mag) : samp_mag;
  end

  assign rem_sh   = {rem, quo[31]};
  assign rem_diff = rem_sh - (RW + 1)'(wn);

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_one  <= RST_MULT_ONE;
      mult_two  <= RST_MULT_TWO;
      start_old <= RST_SEED_OLD;
      start_new <= RST_SEED_NEW;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MULT_ONE: mult_one  <= cfg_data;
        CFG_MULT_TWO: mult_two  <= cfg_data;
        CFG_SEED_OLD: start_old <= cfg_data;
        CFG_SEED_NEW: start_new <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_old  <= RST_SEED_OLD;
      seed_new  <= RST_SEED_NEW;
      gauss_sum <= 32'd0;
      m_valid   <= 1'b0;
    end else begin
      if (ctrl.uop == U_EMIT && out_free) begin
        m_valid <= 1'b1;
      end else if (m_tready) begin
        m_valid <= 1'b0;
      end
      case (ctrl.uop)
        U_FETCH: if (accept) gauss_sum <= 32'd0;
        U_MOD: begin
          seed_old <= seed_new;
          seed_new <= mod_val;
        end
        U_ACC:    gauss_sum <= gauss_sum + sample;
        U_RESEED: begin
          seed_old <= start_old;
          seed_new <= start_new;
        end
        U_ZERO:   gauss_sum <= 32'd0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.uop)
      U_FETCH: begin
        if (accept) begin
          op   <= in_op;
          wn   <= wn_sat;
          cnt  <= CW'(wn_sat) * CW'(wn_sat);
          kmul <= (in_op == OP_HALF) ? 33'(in_spread) : 33'(in_spread) * 33'(SQRT3_Q16);
        end
      end
      U_MUL1: prod <= mult_one * seed_new;
      U_MUL2: prod <= prod - mult_two * seed_old;
      U_MOD: begin
        a      <= mod_val[30:0];
        result <= mod_val;
      end
      U_MAG: begin
        if (a[30]) begin
          mag <= 31'(two_a - MODULUS);
          neg <= 1'b0;
        end else begin
          mag <= 31'(MODULUS - two_a);
          neg <= 1'b1;
        end
      end
      U_SCALE: wide <= 64'(kmul) * 64'(mag);
      U_SAMP: begin
        sample <= samp_val;
        result <= samp_val;
      end
      U_ACC: cnt <= cnt - CW'(1);
      U_DIVINIT: begin
        dneg <= gauss_sum[31];
        quo  <= gauss_sum[31] ? (32'd0 - gauss_sum) : gauss_sum;
        rem  <= '0;
        bits <= 5'd31;
      end
      U_DIVSTEP: begin
        if (!rem_diff[RW]) begin
          rem <= rem_diff[RW-1:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_sh[RW-1:0];
          quo <= {quo[30:0], 1'b0};
        end
        bits <= bits - 5'd1;
      end
      U_DIVEND: result <= dneg ? (32'd0 - quo) : quo;
      U_EMIT:   if (out_free) m_data <= result;
      U_RESEED: result <= 32'd0;
      U_ZERO:   result <= 32'd0;
      default: ;
    endcase
  end

endmodule

// ===== rtl/two_seed_random_generator.sv =====
// Top level of the two-seed random generator: sequencer and datapath.
//
// Items enter on the s_ channel (opcode, spread, gauss_root) and one result
// item leaves on the m_ channel per input item, in order. Configuration writes
// on the cfg_ channel set the two multipliers and the two reseed values; they
// are taken in every cycle and must only come while the block is idle.
// A short control program steps a shared datapath; each item's steps follow its
// opcode and end in the emit step:
//   raw draw                  two multiply steps, then a fold modulo 2^31-1
//   half or full rectangular  a raw draw, then magnitude, scale and sample steps
//   gauss with n = wn*wn      sum of n rectangular draws, divided by wn bit by bit
//   reseed, unused opcode     a zero result; reseed also reloads both seeds
// A new item is accepted only at the start of the program, even while a result
// still waits in the output register. If the receiver stalls, the next result
// waits at the final program step until the output register is free.
// Reset restores the default multipliers and seeds and empties the output.
`timescale 1ns / 1ps
module two_seed_random_generator #(
  parameter int MAX_GAUSS_ROOT = tsrg_pkg::GAUSS_ROOT_MAX
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tsrg_pkg::IN_W-1:0]      s_tdata,   // opcode[2:0], spread[18:3], gauss_root[22:19]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tsrg_pkg::OUT_W-1:0]     m_tdata,   // value[31:0]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tsrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import tsrg_pkg::*;

  ctrl_t   ctrl;
  status_t stat;

  tsrg_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  tsrg_datapath #(
    .MAX_GAUSS_ROOT (MAX_GAUSS_ROOT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the two-seed random generator, with a built-in predictor.
`timescale 1ns / 1ps
module tb;
  import tsrg_pkg::*;

  localparam opcode_t  OP_SPARE_FIRST   = 3'd5;
  localparam int       SPARE_OPS        = 3;
  localparam cfg_idx_t CFG_SPARE_FIRST  = 3'd4;
  localparam int       SPARE_REGS       = 4;
  localparam int       CYCLE_LIMIT      = 2000000;
  localparam int       END_QUIET_CYCLES = 600;
  localparam int       REPORT_LIMIT     = 10;

  logic            clk;
  logic            rst       = 1'b1;
  logic            s_tvalid  = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata   = '0;  // opcode, spread, gauss_root from the lowest bit up
  logic            m_tvalid;
  logic            m_tready  = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // value
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  cfg_idx_t        cfg_index = CFG_MULT_ONE;
  logic [31:0]     cfg_data  = '0;

  logic [31:0] mult_one  = RST_MULT_ONE;
  logic [31:0] mult_two  = RST_MULT_TWO;
  logic [31:0] start_old = RST_SEED_OLD;
  logic [31:0] start_new = RST_SEED_NEW;
  logic [31:0] seed_old  = RST_SEED_OLD;
  logic [31:0] seed_new  = RST_SEED_NEW;

  logic [31:0] expected_values[$];
  logic [31:0] got_value;
  logic [31:0] want_value;
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          cycle_count    = 0;

  two_seed_random_generator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] draw_uniform();
    logic [31:0] x;
    logic [31:0] a;
    x = mult_one * seed_new - mult_two * seed_old;
    a = x % MODULUS;
    seed_old = seed_new;
    seed_new = a;
    return a;
  endfunction

  // floor(w * (2a - M) / 2^sh), worked out on the magnitude.
  function automatic logic signed [63:0] scaled_sample(input logic [63:0] w,
                                                       input logic [31:0] a,
                                                       input int unsigned sh);
    logic [31:0] c_mag;
    logic [63:0] mag;
    if (a >= 32'h4000_0000) begin
      c_mag = {a[30:0], 1'b0} - MODULUS;
      mag = (w * 64'(c_mag)) >> sh;
      return $signed(mag);
    end
    c_mag = MODULUS - {a[30:0], 1'b0};
    mag = (w * 64'(c_mag) + ((64'd1 << sh) - 64'd1)) >> sh;
    return -$signed(mag);
  endfunction

  function automatic logic [31:0] rect_sample(input logic [15:0] spread);
    logic [63:0] w;
    logic [31:0] a;
    logic signed [63:0] s;
    w = 64'(spread);
    w = w * 64'(SQRT3_Q16);
    a = draw_uniform();
    s = scaled_sample(w, a, 47);
    return s[31:0];
  endfunction

  function automatic logic [31:0] predict_value(input opcode_t op, input logic [15:0] spread,
                                                input logic [3:0] root);
    logic [31:0] a;
    logic [63:0] w;
    logic signed [63:0] s;
    int n_root;
    int sum;
    w = 64'(spread);
    case (op)
      OP_RAW: return draw_uniform();
      OP_HALF: begin
        a = draw_uniform();
        s = scaled_sample(w, a, 32);
        return s[31:0];
      end
      OP_RECT: return rect_sample(spread);
      OP_GAUSS: begin
        n_root = (int'(root) > GAUSS_ROOT_MAX) ? GAUSS_ROOT_MAX : int'(root);
        if (n_root == 0) return '0;
        sum = 0;
        for (int i = 0; i < n_root * n_root; i++) sum += $signed(rect_sample(spread));
        return sum / n_root;
      end
      OP_RESEED: begin
        seed_old = start_old;
        seed_new = start_new;
        return '0;
      end
      default: return '0;
    endcase
  endfunction

  function automatic void apply_register(input cfg_idx_t idx, input logic [31:0] data);
    case (idx)
      CFG_MULT_ONE: mult_one = data;
      CFG_MULT_TWO: mult_two = data;
      CFG_SEED_OLD: start_old = data;
      CFG_SEED_NEW: start_new = data;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(255);
      default: return $urandom();
    endcase
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_item(input opcode_t op, input logic [15:0] spread, input logic [3:0] root);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    expected_values.push_back(predict_value(op, spread, root));
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, root, spread, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  task automatic write_one_register(input cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
  endtask

  // An index past the register list is written too; it must change nothing.
  task automatic write_registers(input logic [31:0] m1, input logic [31:0] m2,
                                 input logic [31:0] so, input logic [31:0] sn);
    write_one_register(cfg_idx_t'(CFG_SPARE_FIRST + $urandom_range(SPARE_REGS - 1)), $urandom());
    write_one_register(CFG_MULT_ONE, m1);
    write_one_register(CFG_MULT_TWO, m2);
    write_one_register(CFG_SEED_OLD, so);
    write_one_register(CFG_SEED_NEW, sn);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_items(input int count);
    opcode_t     op;
    logic [15:0] spread;
    logic [3:0]  root;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) op = OP_RAW;
      else if (pick < 40) op = OP_HALF;
      else if (pick < 60) op = OP_RECT;
      else if (pick < 75) op = OP_GAUSS;
      else if (pick < 85) op = OP_RESEED;
      else op = opcode_t'(OP_SPARE_FIRST + $urandom_range(SPARE_OPS - 1));
      case ($urandom_range(5))
        0: spread = 16'h0000;
        1: spread = 16'hFFFF;
        2: spread = 16'($urandom_range(16'h03FF));
        default: spread = 16'($urandom_range(16'hFFFF));
      endcase
      // Long gauss runs are kept rare so most of the time goes to other operations.
      if (op == OP_GAUSS && $urandom_range(9) != 0) root = 4'($urandom_range(3));
      else root = 4'($urandom_range(15));
      send_item(op, spread, root);
    end
  endtask

  task automatic test_directed_ops();
    set_idling(0, 0);
    send_item(OP_RAW, 16'h0000, 4'h0);
    send_item(OP_RAW, 16'hFFFF, 4'hF);
    send_item(OP_HALF, 16'h0000, 4'h0);
    send_item(OP_HALF, 16'hFFFF, 4'h0);
    send_item(OP_HALF, 16'h0100, 4'h5);
    send_item(OP_RECT, 16'hFFFF, 4'hA);
    send_item(OP_RECT, 16'h0000, 4'h0);
    send_item(OP_RECT, 16'h0001, 4'h0);
    // A root of zero draws nothing; roots above the maximum are saturated.
    send_item(OP_GAUSS, 16'hFFFF, 4'h0);
    send_item(OP_GAUSS, 16'hFFFF, 4'h1);
    send_item(OP_GAUSS, 16'h0100, 4'h2);
    send_item(OP_GAUSS, 16'hFFFF, 4'(GAUSS_ROOT_MAX));
    send_item(OP_GAUSS, 16'h0100, 4'h9);
    send_item(OP_GAUSS, 16'hFFFF, 4'hF);
    send_item(OP_RESEED, 16'hFFFF, 4'hF);
    send_item(OP_RAW, 16'h1234, 4'h7);
    for (int k = 0; k < SPARE_OPS; k++) send_item(opcode_t'(OP_SPARE_FIRST + k), 16'hFFFF, 4'hF);
    send_item(OP_RAW, 16'h0000, 4'h0);
    wait_all_results();
  endtask

  // All ones, then all zero (every draw collapses to zero), then a mix.
  task automatic test_register_extremes();
    write_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_idling(45, 0);
    send_item(OP_RESEED, 16'h0000, 4'h0);
    run_random_items(60);
    wait_all_results();
    write_registers(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    set_idling(0, 45);
    send_item(OP_RESEED, 16'h0000, 4'h0);
    run_random_items(30);
    wait_all_results();
    write_registers(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    set_idling(33, 33);
    send_item(OP_RESEED, 16'h0000, 4'h0);
    run_random_items(40);
    wait_all_results();
  endtask

  // Each phase pauses the sender halfway until every result has come back.
  task automatic test_random_registers();
    for (int p = 0; p < 4; p++) begin
      write_registers(random_word(), random_word(), random_word(), random_word());
      case (p)
        0: set_idling(0, 0);
        1: set_idling(45, 0);
        2: set_idling(0, 45);
        default: set_idling(33, 33);
      endcase
      send_item(OP_RESEED, 16'($urandom_range(16'hFFFF)), 4'($urandom_range(15)));
      run_random_items(55);
      wait_all_results();
      run_random_items(55);
      wait_all_results();
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got_value = m_tdata;
      if (expected_values.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result item %h at cycle %0d", got_value, cycle_count);
      end else begin
        want_value = expected_values.pop_front();
        if (got_value !== want_value) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("value mismatch at cycle %0d: expected %h, got %h",
                     cycle_count, want_value, got_value);
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_register_extremes();
    test_random_registers();
    repeat (END_QUIET_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_values.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
